@@ sv/npip_pkg.sv @@
package npip_pkg;

    // Width of a tested term; terms above 2^VALUE_BITS - 1 end the walk.
    localparam int VALUE_BITS = 20;
    // Terms carry one extra bit so that term + step cannot wrap.
    localparam int TERM_BITS  = VALUE_BITS + 1;
    // Trial divisor: reaches just past sqrt(2^VALUE_BITS).
    localparam int DV_BITS    = (VALUE_BITS + 1) / 2 + 1;
    // Bit counter of the serial remainder unit.
    localparam int CNT_BITS   = $clog2(TERM_BITS);
    // Field widths of the transfer.
    localparam int START_BITS = 16;
    localparam int STEP_BITS  = 10;
    localparam int IDX_BITS   = 10;

    localparam logic [TERM_BITS-1:0] LIMIT = {1'b0, {VALUE_BITS{1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD,
        S_GCD_DIV,
        S_TEST_INIT,
        S_TEST_CHK,
        S_TEST_DIV,
        S_HIT,
        S_MISS,
        S_DONE
    } t_state;

endpackage

@@ sv/nth_prime_in_progression_top.sv @@
// Flow: Euclid on start and step runs one serial remainder per step, then each term
// is tried by a serial remainder for each trial divisor d with d*d <= term until a
// factor is found; a final state stages the result in the output register.
// Throughput: one item at a time; the next transfer is taken once the result is
// staged in the output register.
// Reset: synchronous, active low; clears the state machine and the output valid.
module nth_prime_in_progression_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [npip_pkg::START_BITS-1:0]   i_start_value,
    input  logic [npip_pkg::STEP_BITS-1:0]    i_step_size,
    input  logic [npip_pkg::IDX_BITS-1:0]     i_prime_index,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [npip_pkg::VALUE_BITS-1:0]   o_prime_value,
    output logic                              o_overflow
);
    import npip_pkg::*;

    t_state                 r_state, n_state;
    logic [TERM_BITS-1:0]   r_term, n_term;
    logic [STEP_BITS-1:0]   r_step, n_step;
    logic [IDX_BITS-1:0]    r_want, n_want;
    logic [IDX_BITS-1:0]    r_found, n_found;
    logic                   r_walk, n_walk;
    logic [TERM_BITS-1:0]   r_ga, n_ga;
    logic [TERM_BITS-1:0]   r_gb, n_gb;
    logic [DV_BITS-1:0]     r_dv, n_dv;
    logic [TERM_BITS-1:0]   r_sq, n_sq;
    logic [TERM_BITS-1:0]   r_dsh, n_dsh;
    logic [TERM_BITS-1:0]   r_rem, n_rem;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic                   r_res_ovf, n_res_ovf;
    logic                   r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0]  r_prime_value, n_prime_value;
    logic                   r_overflow, n_overflow;

    logic [TERM_BITS-1:0]   divisor;
    logic [TERM_BITS:0]     rem_sh;
    logic [TERM_BITS:0]     rem_sub;
    logic [TERM_BITS-1:0]   rem_nx;
    logic                   start_over;

    // One restoring division step: bring in the next dividend bit, subtract if it fits.
    always_comb begin
        divisor = (r_state == S_GCD_DIV) ? r_gb : TERM_BITS'(r_dv);
        rem_sh  = {r_rem, r_dsh[TERM_BITS-1]};
        rem_sub = rem_sh - {1'b0, divisor};
        if (rem_sh >= {1'b0, divisor}) begin
            rem_nx = rem_sub[TERM_BITS-1:0];
        end else begin
            rem_nx = rem_sh[TERM_BITS-1:0];
        end
    end

    assign start_over = 32'(i_start_value) > 32'(LIMIT);

    // Next state and datapath updates.
    always_comb begin
        n_state       = r_state;
        n_term        = r_term;
        n_step        = r_step;
        n_want        = r_want;
        n_found       = r_found;
        n_walk        = r_walk;
        n_ga          = r_ga;
        n_gb          = r_gb;
        n_dv          = r_dv;
        n_sq          = r_sq;
        n_dsh         = r_dsh;
        n_rem         = r_rem;
        n_cnt         = r_cnt;
        n_res_ovf     = r_res_ovf;
        n_out_valid   = r_out_valid;
        n_prime_value = r_prime_value;
        n_overflow    = r_overflow;

        // The output register empties on a transfer.
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_term  = TERM_BITS'(i_start_value);
                    n_step  = i_step_size;
                    n_want  = (i_prime_index == '0) ? IDX_BITS'(1) : i_prime_index;
                    n_found = '0;
                    n_ga    = TERM_BITS'(i_start_value);
                    n_gb    = TERM_BITS'(i_step_size);
                    if (start_over) begin
                        n_res_ovf = 1'b1;
                        n_state   = S_DONE;
                    end else if (i_step_size == '0) begin
                        n_walk  = 1'b0;
                        n_state = S_TEST_INIT;
                    end else begin
                        n_state = S_GCD;
                    end
                end
            end
            // Euclid on start and step; a common factor leaves only the first term.
            S_GCD: begin
                if (r_gb == '0) begin
                    if (r_ga > TERM_BITS'(1)) begin
                        n_walk = 1'b0;
                        if (r_want == IDX_BITS'(1)) begin
                            n_state = S_TEST_INIT;
                        end else begin
                            n_res_ovf = 1'b1;
                            n_state   = S_DONE;
                        end
                    end else begin
                        n_walk  = 1'b1;
                        n_state = S_TEST_INIT;
                    end
                end else begin
                    n_dsh   = r_ga;
                    n_rem   = '0;
                    n_cnt   = CNT_BITS'(TERM_BITS - 1);
                    n_state = S_GCD_DIV;
                end
            end
            S_GCD_DIV: begin
                n_dsh = {r_dsh[TERM_BITS-2:0], 1'b0};
                n_rem = rem_nx;
                n_cnt = r_cnt - CNT_BITS'(1);
                if (r_cnt == '0) begin
                    n_ga    = r_gb;
                    n_gb    = rem_nx;
                    n_state = S_GCD;
                end
            end
            // Start a primality test of the current term.
            S_TEST_INIT: begin
                if (r_term > LIMIT) begin
                    n_res_ovf = 1'b1;
                    n_state   = S_DONE;
                end else if (r_term < TERM_BITS'(2)) begin
                    n_state = S_MISS;
                end else begin
                    n_dv    = DV_BITS'(2);
                    n_sq    = TERM_BITS'(4);
                    n_state = S_TEST_CHK;
                end
            end
            S_TEST_CHK: begin
                if (r_sq > r_term) begin
                    n_state = S_HIT;
                end else begin
                    n_dsh   = r_term;
                    n_rem   = '0;
                    n_cnt   = CNT_BITS'(TERM_BITS - 1);
                    n_state = S_TEST_DIV;
                end
            end
            // Serial remainder of term by divisor; square tracks (d+1)^2 = d^2 + 2d + 1.
            S_TEST_DIV: begin
                n_dsh = {r_dsh[TERM_BITS-2:0], 1'b0};
                n_rem = rem_nx;
                n_cnt = r_cnt - CNT_BITS'(1);
                if (r_cnt == '0) begin
                    if (rem_nx == '0) begin
                        n_state = S_MISS;
                    end else begin
                        n_dv    = r_dv + DV_BITS'(1);
                        n_sq    = r_sq + TERM_BITS'({r_dv, 1'b1});
                        n_state = S_TEST_CHK;
                    end
                end
            end
            S_HIT: begin
                if (!r_walk || (r_found + IDX_BITS'(1)) == r_want) begin
                    n_res_ovf = 1'b0;
                    n_state   = S_DONE;
                end else begin
                    n_found = r_found + IDX_BITS'(1);
                    n_term  = r_term + TERM_BITS'(r_step);
                    n_state = S_TEST_INIT;
                end
            end
            S_MISS: begin
                if (!r_walk) begin
                    n_res_ovf = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_term  = r_term + TERM_BITS'(r_step);
                    n_state = S_TEST_INIT;
                end
            end
            // Load the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_prime_value = r_res_ovf ? '0 : r_term[VALUE_BITS-1:0];
                    n_overflow    = r_res_ovf;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_term        <= n_term;
        r_step        <= n_step;
        r_want        <= n_want;
        r_found       <= n_found;
        r_walk        <= n_walk;
        r_ga          <= n_ga;
        r_gb          <= n_gb;
        r_dv          <= n_dv;
        r_sq          <= n_sq;
        r_dsh         <= n_dsh;
        r_rem         <= n_rem;
        r_cnt         <= n_cnt;
        r_res_ovf     <= n_res_ovf;
        r_prime_value <= n_prime_value;
        r_overflow    <= n_overflow;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_prime_value = r_prime_value;
    assign o_overflow    = r_overflow;

endmodule
